FILE: rtl/pcx_rle_palette_decoder_assert.svh
// Assertion macros for the PCX run-length palette decoder.
`ifndef PCX_RLE_PALETTE_DECODER_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_ASSERT_SVH
`ifndef SYNTH
`define PCX_ASSERT(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (!r) p) \
    else $error("pcx decoder assertion failed");
`define PCX_ASSERT_ALWAYS(lbl, c, p) \
  lbl: assert property (@(posedge c) p) \
    else $error("pcx decoder assertion failed");
`else
`define PCX_ASSERT(lbl, c, r, p)
`define PCX_ASSERT_ALWAYS(lbl, c, p)
`endif
`endif

FILE: rtl/pcx_pkg.sv
// Shared types and constants of the PCX run-length palette decoder.
`default_nettype none
package pcx_pkg;

  localparam int CFG_W           = 13;
  localparam int COL_W           = 14;
  localparam int CNT_W           = 6;
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = 8;
  localparam int MAX_DIMENSION   = 4096;
  localparam int DIM_CAP         = (MAX_DIMENSION > (2**CFG_W - 1)) ? (2**CFG_W - 1)
                                                                     : MAX_DIMENSION;
  localparam logic [CFG_W-1:0] DIM_LIMIT = CFG_W'(DIM_CAP);

  localparam logic [1:0] RUN_MARK      = 2'b11;
  localparam logic       MODE_PALETTE  = 1'b0;
  localparam logic       MODE_IMAGE    = 1'b1;
  localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    COMP_R,
    COMP_G,
    COMP_B
  } comp_t;

  typedef struct packed {
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
  } rgb_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    logic             eoi;
  } emit_req_t;

endpackage
`default_nettype wire

FILE: rtl/pcx_cmem.sv
// Colour table memory: one write port, one registered read port.
`default_nettype none
module pcx_cmem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [pcx_pkg::IDX_W-1:0] waddr,
  input  wire pcx_pkg::rgb_t             wdata,
  input  wire logic                      re,
  input  wire logic [pcx_pkg::IDX_W-1:0] raddr,
  output pcx_pkg::rgb_t                  rdata
);
  import pcx_pkg::*;

  rgb_t mem [PALETTE_ENTRIES];
  rgb_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/pcx_ctrl.sv
// Palette fill, run decoding and image position tracking.
`default_nettype none
module pcx_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic                      mode,
  input  wire logic [7:0]                din,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [pcx_pkg::CFG_W-1:0] cfg_data,
  output logic                           mem_we,
  output logic [pcx_pkg::IDX_W-1:0]      mem_waddr,
  output pcx_pkg::rgb_t                  mem_wdata,
  output logic                           mem_re,
  output logic [pcx_pkg::IDX_W-1:0]      mem_raddr,
  output pcx_pkg::emit_req_t             req
);
  import pcx_pkg::*;

  logic [CFG_W-1:0] width_r, height_r;
  logic [IDX_W:0]   entry_r, entry_nxt;
  comp_t            comp_r, comp_nxt;
  logic [5:0]       r_stage_r, r_stage_nxt, g_stage_r, g_stage_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CFG_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;

  logic [CFG_W-1:0] cw, ch;
  logic [COL_W-1:0] w_ext, stride, room, n_ext, add, col_sum, row_inc;
  logic [CNT_W-1:0] put_count, n;
  logic             in_row, wrap, eoi, image_dn, run_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(1);
      height_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cw       = (width_r > DIM_LIMIT) ? DIM_LIMIT : width_r;
  assign ch       = (height_r > DIM_LIMIT) ? DIM_LIMIT : height_r;
  assign w_ext    = {1'b0, cw};
  assign stride   = w_ext + {{(COL_W-1){1'b0}}, cw[0]};
  assign image_dn = done_r || (row_r >= ch);
  assign run_code = (din[7:6] == RUN_MARK);

  assign put_count = pend_r ? cnt_r : CNT_W'(1);
  assign in_row    = (col_r < w_ext);
  assign room      = w_ext - col_r;
  assign n         = !in_row ? '0 :
                     (({{(COL_W-CNT_W){1'b0}}, put_count} > room) ? room[CNT_W-1:0]
                                                                  : put_count);
  assign n_ext     = {{(COL_W-CNT_W){1'b0}}, n};
  assign add       = in_row ? n_ext : {{(COL_W-CNT_W){1'b0}}, put_count};
  assign col_sum   = col_r + add;
  assign wrap      = (col_sum >= stride);
  assign row_inc   = {1'b0, row_r} + COL_W'(1);
  assign eoi       = (row_inc == {1'b0, ch}) && ((col_r + n_ext) == w_ext);

  always_comb begin
    entry_nxt   = entry_r;
    comp_nxt    = comp_r;
    r_stage_nxt = r_stage_r;
    g_stage_nxt = g_stage_r;
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    done_nxt    = done_r;
    mem_we      = 1'b0;
    mem_waddr   = entry_r[IDX_W-1:0];
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = din;
    req         = '0;
    if (accept) begin
      if (mode == MODE_PALETTE) begin
        if (!entry_r[IDX_W]) begin
          mem_we = 1'b1;
          case (comp_r)
            COMP_R: begin
              mem_wdata   = '{r: din[7:2], g: 6'd0, b: 6'd0};
              r_stage_nxt = din[7:2];
              comp_nxt    = COMP_G;
            end
            COMP_G: begin
              mem_wdata   = '{r: r_stage_r, g: din[7:2], b: 6'd0};
              g_stage_nxt = din[7:2];
              comp_nxt    = COMP_B;
            end
            COMP_B: begin
              mem_wdata = '{r: r_stage_r, g: g_stage_r, b: din[7:2]};
              comp_nxt  = COMP_R;
              entry_nxt = entry_r + (IDX_W+1)'(1);
            end
            default: begin
              mem_we   = 1'b0;
              comp_nxt = COMP_R;
            end
          endcase
        end
        pend_nxt = 1'b0;
        cnt_nxt  = '0;
        col_nxt  = '0;
        row_nxt  = '0;
        done_nxt = 1'b0;
      end else begin
        mem_re = 1'b1;
        if (image_dn) begin
          done_nxt = 1'b1;
        end else if (pend_r || !run_code) begin
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          req.valid = (n != '0);
          req.count = n;
          req.eoi   = eoi;
          if (wrap) begin
            col_nxt = '0;
            row_nxt = row_inc[CFG_W-1:0];
            if (row_inc >= {1'b0, ch}) begin
              done_nxt = 1'b1;
            end
          end else begin
            col_nxt = col_sum;
          end
        end else begin
          pend_nxt = 1'b1;
          cnt_nxt  = din[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      comp_r  <= COMP_R;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      comp_r  <= comp_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_stage_r <= r_stage_nxt;
    g_stage_r <= g_stage_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/pcx_emit.sv
// Pixel emitter: repeats the fetched colour for the run length.
`default_nettype none
`include "pcx_rle_palette_decoder_assert.svh"
module pcx_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcx_pkg::emit_req_t req,
  input  wire pcx_pkg::rgb_t      rgb,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [23:0]             out_tdata,
  output logic                    out_tlast,
  output logic [0:0]              out_tuser
);
  import pcx_pkg::*;

  logic             out_tvalid_r;
  logic [CNT_W-1:0] emit_left_r;
  logic             eoi_r;
  logic             last;

  assign last      = (emit_left_r == CNT_W'(1));
  assign in_tready = !out_tvalid_r || (out_tready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      emit_left_r  <= '0;
    end else if (req.valid) begin
      out_tvalid_r <= 1'b1;
      emit_left_r  <= req.count;
    end else if (out_tvalid_r && out_tready) begin
      if (last) begin
        out_tvalid_r <= 1'b0;
      end
      emit_left_r <= emit_left_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      eoi_r <= req.eoi;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, rgb.b, rgb.g, rgb.r};
  assign out_tlast  = last;
  assign out_tuser  = eoi_r && last;

  `PCX_ASSERT(a_valid_has_count, clk, rst_n, out_tvalid_r |-> (emit_left_r != '0))
  `PCX_ASSERT(a_run_continues, clk, rst_n,
              (out_tvalid_r && out_tready && !last) |=> out_tvalid_r)
  `PCX_ASSERT(a_stall_holds_count, clk, rst_n,
              (out_tvalid_r && !out_tready) |=> $stable(emit_left_r))
  `PCX_ASSERT(a_req_when_ready, clk, rst_n, req.valid |-> in_tready)

endmodule
`default_nettype wire

FILE: rtl/pcx_rle_palette_decoder.sv
// A pixel is offered in the cycle after the transfer of the byte that causes it.
// Throughput: literal and palette bytes one per cycle while the output is not stalled; a run
// colour byte holds the input until the output takes the last pixel of its run.
// The colour table memory is read once per image byte; its registered port feeds the output.
// Reset: synchronous active-low rst_n clears position, run, fill and output state.
// The colour table is not cleared; entries are defined once written by palette bytes.
`default_nettype none
module pcx_rle_palette_decoder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [7:0]                in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [23:0]                    out_tdata,  // [5:0] red, [11:6] green, [17:12] blue
  output logic                           out_tlast,  // last_of_run
  output logic [0:0]                     out_tuser,  // [0] end_of_image
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [pcx_pkg::CFG_W-1:0] cfg_data
);
  import pcx_pkg::*;

  logic             accept;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  rgb_t             mem_wdata, mem_rdata;
  emit_req_t        req;

  assign accept = in_tvalid && in_tready;

  pcx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_tuser[0]),
    .din       (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .req       (req)
  );

  pcx_cmem u_cmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pcx_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .rgb        (mem_rdata),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
